FILE: design/kwm_pkg.sv
// Shared constants, codes, types and helpers for the k-way sorted merge core.
package kwm_pkg;

   localparam int LISTS       = 8;
   localparam int DEPTH       = 64;
   localparam int VALUE_W     = 32;
   localparam int LIST_NUM_W  = 3;
   localparam int LIST_W      = $clog2(LISTS);
   localparam int LEAVES      = 1 << LIST_W;
   localparam int POS_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int STORE_DEPTH = LISTS * DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Winner of the head compare
   typedef struct packed {
      logic                      found;
      logic [LIST_W-1:0]         index;
      logic signed [VALUE_W-1:0] value;
   } head_pick_type;

   // Store update for one item
   typedef struct packed {
      logic                      push;
      logic                      pop;
      logic                      clear;
      logic [LIST_W-1:0]         push_list;
      logic signed [VALUE_W-1:0] push_value;
   } list_op_type;

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos);
      return (pos == POS_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [LIST_W-1:0] lst,
                                                    input logic [POS_W-1:0]  pos);
      return ADDR_W'(lst) * ADDR_W'(DEPTH) + ADDR_W'(pos);
   endfunction

endpackage

FILE: design/kwm_if.sv
// Request and response channel interfaces of the k-way sorted merge core.
interface kwm_req_if import kwm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   func_type                  func;
   logic [LIST_NUM_W-1:0]     list_number;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, func, list_number, value, input ready);
   modport sink   (input valid, func, list_number, value, output ready);
endinterface

interface kwm_rsp_if import kwm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   status_type                status;
   logic signed [VALUE_W-1:0] merged_value;
   logic [LIST_NUM_W-1:0]     source_list;

   modport source (output valid, status, merged_value, source_list, input ready);
   modport sink   (input valid, status, merged_value, source_list, output ready);
endinterface

FILE: design/kwm_min_tree.sv
// Compare tree that picks the smallest valid head, lowest list number on ties.
module kwm_min_tree import kwm_pkg::*; (
   input  logic signed [VALUE_W-1:0] head_value [LISTS],
   input  logic                      head_valid [LISTS],
   output head_pick_type             pick
);

   logic                      node_valid [2*LEAVES];
   logic [LIST_W-1:0]         node_index [2*LEAVES];
   logic signed [VALUE_W-1:0] node_value [2*LEAVES];

   always_comb begin
      for (int n = 0; n < 2*LEAVES; n++) begin
         node_valid[n] = 1'b0;
         node_index[n] = '0;
         node_value[n] = '0;
      end
      for (int j = 0; j < LISTS; j++) begin
         node_valid[LEAVES+j] = head_valid[j];
         node_index[LEAVES+j] = LIST_W'(j);
         node_value[LEAVES+j] = head_value[j];
      end
      // Right child wins only when strictly smaller
      for (int n = LEAVES - 1; n >= 1; n--) begin
         if (node_valid[2*n+1] &&
             (!node_valid[2*n] || node_value[2*n+1] < node_value[2*n])) begin
            node_valid[n] = 1'b1;
            node_index[n] = node_index[2*n+1];
            node_value[n] = node_value[2*n+1];
         end else begin
            node_valid[n] = node_valid[2*n];
            node_index[n] = node_index[2*n];
            node_value[n] = node_value[2*n];
         end
      end
   end

   assign pick.found = node_valid[1];
   assign pick.index = node_index[1];
   assign pick.value = node_value[1];

endmodule

FILE: design/kwm_list_store.sv
// Per-list FIFO state, head registers, element memory and head refill.
module kwm_list_store import kwm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  list_op_type   op,
   output head_pick_type pick,
   output logic [LISTS-1:0] full
);

   logic [CNT_W-1:0]          count_ff  [LISTS];
   logic [CNT_W-1:0]          count_in  [LISTS];
   logic [POS_W-1:0]          rd_pos_ff [LISTS];
   logic [POS_W-1:0]          rd_pos_in [LISTS];
   logic [POS_W-1:0]          wr_pos_ff [LISTS];
   logic [POS_W-1:0]          wr_pos_in [LISTS];
   logic signed [VALUE_W-1:0] head_ff   [LISTS];
   logic signed [VALUE_W-1:0] head_now  [LISTS];
   logic                      head_valid [LISTS];

   logic                      refill_pend_ff;
   logic                      refill_pend_in;
   logic [LIST_W-1:0]         refill_list_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ADDR_W-1:0]         wr_addr;
   logic [POS_W-1:0]          pop_next_pos;

   logic signed [VALUE_W-1:0] mem [STORE_DEPTH];

   // A refilled head arrives in the cycle after its pop; bypass it until written
   always_comb begin
      for (int i = 0; i < LISTS; i++) begin
         head_now[i]   = (refill_pend_ff && refill_list_ff == LIST_W'(i)) ?
                         rd_data_ff : head_ff[i];
         head_valid[i] = (count_ff[i] != '0);
         full[i]       = (count_ff[i] == CNT_W'(DEPTH));
      end
   end

   kwm_min_tree u_min_tree (
      .head_value (head_now),
      .head_valid (head_valid),
      .pick       (pick)
   );

   assign pop_next_pos   = next_pos(rd_pos_ff[pick.index]);
   assign rd_addr        = store_addr(pick.index, pop_next_pos);
   assign wr_addr        = store_addr(op.push_list, wr_pos_ff[op.push_list]);
   assign refill_pend_in = op.pop && (count_ff[pick.index] > CNT_W'(1));

   always_comb begin
      for (int i = 0; i < LISTS; i++) begin
         count_in[i]  = count_ff[i];
         rd_pos_in[i] = rd_pos_ff[i];
         wr_pos_in[i] = wr_pos_ff[i];
      end
      if (op.clear) begin
         for (int i = 0; i < LISTS; i++) begin
            count_in[i]  = '0;
            rd_pos_in[i] = '0;
            wr_pos_in[i] = '0;
         end
      end else if (op.push) begin
         count_in[op.push_list]  = count_ff[op.push_list] + 1'b1;
         wr_pos_in[op.push_list] = next_pos(wr_pos_ff[op.push_list]);
      end else if (op.pop) begin
         count_in[pick.index]  = count_ff[pick.index] - 1'b1;
         rd_pos_in[pick.index] = pop_next_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LISTS; i++) begin
            count_ff[i]  <= '0;
            rd_pos_ff[i] <= '0;
            wr_pos_ff[i] <= '0;
         end
         refill_pend_ff <= 1'b0;
      end else begin
         for (int i = 0; i < LISTS; i++) begin
            count_ff[i]  <= count_in[i];
            rd_pos_ff[i] <= rd_pos_in[i];
            wr_pos_ff[i] <= wr_pos_in[i];
         end
         refill_pend_ff <= refill_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.pop) begin
         refill_list_ff <= pick.index;
      end
      if (refill_pend_ff) begin
         head_ff[refill_list_ff] <= rd_data_ff;
      end
      // Load the head directly when pushing into an empty list
      if (op.push && count_ff[op.push_list] == '0) begin
         head_ff[op.push_list] <= op.push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[wr_addr] <= op.push_value;
      end
      if (refill_pend_in) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(op.push && op.pop) && !(op.push && op.clear) && !(op.pop && op.clear))
      else $error("more than one store update in a cycle");

   assert property (@(posedge clock) disable iff (reset) op.pop |-> pick.found)
      else $error("pop issued with no valid head");

   assert property (@(posedge clock) disable iff (reset)
      refill_pend_ff |-> (count_ff[refill_list_ff] != '0))
      else $error("head refill pending for an empty list");

   assert property (@(posedge clock) disable iff (reset)
      op.push |-> !full[op.push_list])
      else $error("push issued to a full list");

endmodule

FILE: design/k_way_sorted_merge_core.sv
// Response path: the accepted request is held in the input register, then the result register.
// One item per cycle unless rsp stalls; pop compares all heads in one tree, refill overlaps.
// The element memory is one write and one read port with a registered read.
// Reset (synchronous, active high) empties every list and drops items in flight.
// No clearing pass: element memory contents are not reset and only written entries are read.
// Top level of the k-way sorted merge core: item pipeline and response register.
module k_way_sorted_merge_core import kwm_pkg::*; (
   input logic clock,
   input logic reset,
   kwm_req_if.sink   req_chan,
   kwm_rsp_if.source rsp_chan
);

   logic                      s1_valid_ff;
   func_type                  s1_func_ff;
   logic [LIST_NUM_W-1:0]     s1_list_ff;
   logic signed [VALUE_W-1:0] s1_value_ff;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   status_type                rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic signed [VALUE_W-1:0] rsp_value_in;
   logic [LIST_NUM_W-1:0]     rsp_source_ff;
   logic [LIST_NUM_W-1:0]     rsp_source_in;

   logic              advance;
   logic              process;
   logic              list_in_range;
   logic [LIST_W-1:0] sel_list;
   logic              push_full;
   list_op_type       op;
   head_pick_type     pick;
   logic [LISTS-1:0]  full;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign process        = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;

   assign list_in_range = (int'(s1_list_ff) < LISTS);
   assign sel_list      = LIST_W'(s1_list_ff);
   assign push_full     = !list_in_range || full[sel_list];

   always_comb begin
      op            = '0;
      op.push_list  = sel_list;
      op.push_value = s1_value_ff;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      rsp_source_in = '0;
      case (s1_func_ff)
         FUNC_PUSH: begin
            if (push_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               op.push = process;
            end
         end
         FUNC_POP: begin
            if (pick.found) begin
               op.pop        = process;
               rsp_value_in  = pick.value;
               rsp_source_in = LIST_NUM_W'(pick.index);
            end else begin
               rsp_status_in = ST_EMPTY;
            end
         end
         FUNC_CLEAR: begin
            op.clear = process;
         end
         default: begin
            // unused code: no state change
         end
      endcase
   end

   kwm_list_store u_list_store (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .pick  (pick),
      .full  (full)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_func_ff  <= req_chan.func;
         s1_list_ff  <= req_chan.list_number;
         s1_value_ff <= req_chan.value;
      end
      if (process) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_source_ff <= rsp_source_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.merged_value = rsp_value_ff;
   assign rsp_chan.source_list  = rsp_source_ff;

endmodule

FILE: test/tb.sv
// Testbench for the k-way sorted merge core: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb;
   import kwm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_MAX    = 10;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] value;
      logic [LIST_NUM_W-1:0]     source;
   } merge_result_type;

   logic clock = 1'b0;
   logic reset;

   kwm_req_if req_chan ();
   kwm_rsp_if rsp_chan ();

   k_way_sorted_merge_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state
   logic signed [VALUE_W-1:0] list_mem [LISTS][DEPTH];
   int                        head_pos [LISTS];
   int                        tail_pos [LISTS];
   int                        list_fill [LISTS];
   merge_result_type          pending_results [$];

   // Stimulus state: next ascending value per list
   logic signed [VALUE_W-1:0] next_val [LISTS];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int cycles         = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void merge_predict(func_type f, int lst, logic signed [VALUE_W-1:0] v);
      merge_result_type res;
      bit               found;
      int               best;
      res.status = ST_OK;
      res.value  = '0;
      res.source = '0;
      found      = 1'b0;
      best       = 0;
      case (f)
         FUNC_PUSH: begin
            if (lst >= LISTS || list_fill[lst] >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               list_mem[lst][tail_pos[lst]] = v;
               tail_pos[lst] = (tail_pos[lst] + 1) % DEPTH;
               list_fill[lst]++;
            end
         end
         FUNC_POP: begin
            // strict less-than keeps the lowest list on equal heads
            for (int i = 0; i < LISTS; i++) begin
               if (list_fill[i] != 0 &&
                   (!found || list_mem[i][head_pos[i]] < list_mem[best][head_pos[best]])) begin
                  found = 1'b1;
                  best  = i;
               end
            end
            if (!found) begin
               res.status = ST_EMPTY;
            end else begin
               res.value  = list_mem[best][head_pos[best]];
               res.source = LIST_NUM_W'(best);
               head_pos[best] = (head_pos[best] + 1) % DEPTH;
               list_fill[best]--;
            end
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < LISTS; i++) begin
               head_pos[i]  = 0;
               tail_pos[i]  = 0;
               list_fill[i] = 0;
            end
         end
         default: ;
      endcase
      pending_results = {pending_results, res};
   endfunction

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= SHOW_MAX) $display("mismatch: %s", msg);
   endfunction

   // Receiver: stall at the falling edge, check at the rising edge
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      merge_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result status=%0d value=%0d list=%0d",
                                    rsp_chan.status, rsp_chan.merged_value,
                                    rsp_chan.source_list));
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.status !== want.status || rsp_chan.merged_value !== want.value ||
                rsp_chan.source_list !== want.source) begin
               note_mismatch($sformatf(
                  "expected status=%0d value=%0d list=%0d, got status=%0d value=%0d list=%0d",
                  want.status, want.value, want.source, rsp_chan.status,
                  rsp_chan.merged_value, rsp_chan.source_list));
            end
         end
      end
   end

   // Send one item; valid stays high after acceptance until the next call decides
   task automatic send_item(func_type f, int lst, logic signed [VALUE_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.func        <= f;
      req_chan.list_number <= LIST_NUM_W'(lst);
      req_chan.value       <= v;
      do @(posedge clock); while (!req_chan.ready);
      merge_predict(f, lst, v);
   endtask

   // Hold off the sender until every result is back
   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] start_value();
      case ($urandom_range(0, 3))
         0: return -32'sd2147483648 + $urandom_range(0, 500);
         1: return $signed($urandom_range(0, 200)) - 100;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic void restart_values();
      logic signed [VALUE_W-1:0] shared;
      shared = start_value();
      for (int i = 0; i < LISTS; i++) begin
         // equal starts across lists provoke equal heads
         next_val[i] = ($urandom_range(0, 2) == 0) ? shared : start_value();
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] next_value(int lst);
      longint step;
      longint nxt;
      if ($urandom_range(0, 19) == 0) return $signed($urandom);
      step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1000);
      nxt  = longint'(next_val[lst]) + step;
      if (nxt > longint'(32'sh7fffffff)) begin
         next_val[lst] = {1'b1, 31'($urandom)};
      end else begin
         next_val[lst] = VALUE_W'(nxt);
      end
      return next_val[lst];
   endfunction

   task automatic test_directed();
      send_item(FUNC_POP, 0, 0);
      send_item(FUNC_PUSH, 7, 32'sh7fffffff);
      send_item(FUNC_PUSH, 0, -32'sd2147483648);
      send_item(FUNC_PUSH, 3, 0);
      send_item(FUNC_PUSH, 5, 0);
      send_item(FUNC_PUSH, 1, -1);
      repeat (5) send_item(FUNC_POP, 7, 32'sh7fffffff);
      send_item(FUNC_POP, 0, 0);
      send_item(FUNC_PUSH, 2, 5);
      send_item(FUNC_PUSH, 6, 5);
      send_item(FUNC_CLEAR, 7, -1);
      send_item(FUNC_POP, 0, 0);
      send_item(FUNC_PUSH, 4, 32'sh55555555);
      send_item(FUNC_PUSH, 4, 32'shaaaaaaaa);
      send_item(FUNC_PUSH, 6, -5);
      repeat (4) send_item(FUNC_POP, 0, 0);
   endtask

   // Fill one list past full, then pop and refill so both positions wrap
   task automatic fill_and_wrap();
      int lst;
      lst = $urandom_range(0, LISTS - 1);
      send_item(FUNC_CLEAR, $urandom_range(0, 7), $signed($urandom));
      restart_values();
      repeat (DEPTH + 2) send_item(FUNC_PUSH, lst, next_value(lst));
      repeat (DEPTH / 2) send_item(FUNC_POP, $urandom_range(0, 7), $signed($urandom));
      repeat (DEPTH / 2) send_item(FUNC_PUSH, lst, next_value(lst));
      repeat (DEPTH) send_item(FUNC_POP, $urandom_range(0, 7), $signed($urandom));
   endtask

   task automatic random_mix(int count);
      int pick;
      int lst;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         lst  = $urandom_range(0, LISTS - 1);
         if (pick < 50) begin
            send_item(FUNC_PUSH, lst, next_value(lst));
         end else if (pick < 98) begin
            send_item(FUNC_POP, lst, $signed($urandom));
         end else begin
            send_item(FUNC_CLEAR, lst, $signed($urandom));
            restart_values();
         end
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      fill_and_wrap();
      random_mix(155);
      wait_for_results();
   endtask

   task automatic test_no_idle();
      run_phase(0, 0);
   endtask

   task automatic test_sender_idle();
      run_phase(79, 0);
   endtask

   task automatic test_receiver_stall();
      run_phase(0, 79);
   endtask

   task automatic test_both_idle();
      run_phase(25, 25);
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.func        = FUNC_PUSH;
      req_chan.list_number = '0;
      req_chan.value       = '0;
      for (int i = 0; i < LISTS; i++) begin
         head_pos[i]  = 0;
         tail_pos[i]  = 0;
         list_fill[i] = 0;
      end
      restart_values();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      wait_for_results();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
